>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`endif
`endif

>>> hdl/rut_pkg.sv
`default_nettype none
package rut_pkg;
   localparam int SEQ_BITS    = 16;
   localparam int ACK_WINDOW  = 32;
   localparam int QUEUE_DEPTH = 16;
   localparam int SLOTS       = 16;
   localparam int READ_CAP    = 200;
   localparam int TIME_W      = 32;
   localparam int READS_W     = 8;
   localparam int SLOT_W      = $clog2(SLOTS);
   localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int WIDX_W      = $clog2(ACK_WINDOW);
   localparam int ADDR_W      = SLOT_W + QIDX_W;

   typedef logic [SEQ_BITS-1:0]   seq_type;
   typedef logic [ACK_WINDOW-1:0] window_type;
   typedef logic [TIME_W-1:0]     time_type;

   typedef enum logic [1:0] {CMD_OPEN, CMD_SEND, CMD_RECV, CMD_TICK} cmd_type;
   typedef enum logic [2:0] {
      EV_SEND, EV_RCPT_OK, EV_RCPT_FAIL, EV_DELIVER, EV_DISCONNECT, EV_REJECT, EV_OPENED
   } event_type;
   typedef enum logic [1:0] {CSR_RCPT_EN, CSR_RCPT_TO, CSR_KEEPALIVE, CSR_DISC_TO} csr_index_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_OPEN, OP_LOAD, OP_SEND, OP_RXUPD, OP_ACK, OP_DELIVER,
      OP_FAIL_HEAD, OP_DISC, OP_STORE, OP_FLUSH
   } dp_op_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  conn_id;
      time_type    now_ms;
      seq_type     rx_seq;
      seq_type     rx_ack_seq;
      window_type  rx_ack_bits;
      logic        rx_has_payload;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [3:0]  event_conn;
      seq_type     event_seq;
      seq_type     tx_ack_seq;
      window_type  tx_ack_bits;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic      latch;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic              active;
      logic              rcpt;
      logic              pay;
      logic              emit_ok;
      logic              load_done;
      logic              store_done;
      logic              hold_v;
      logic              force_ack;
      logic              keep_due;
      logic              expire_due;
      logic              disc_due;
      logic              ack_done;
      logic              cnt_zero;
      logic [CNT_W-1:0]  cnt;
   } dp_status_type;
endpackage
`default_nettype wire

>>> hdl/rut_if.sv
`default_nettype none
interface rut_req_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              command;
   logic [3:0]              conn_id;
   rut_pkg::time_type       now_ms;
   rut_pkg::seq_type        rx_seq;
   rut_pkg::seq_type        rx_ack_seq;
   rut_pkg::window_type     rx_ack_bits;
   logic                    rx_has_payload;
   modport source (output valid, command, conn_id, now_ms, rx_seq, rx_ack_seq,
                   rx_ack_bits, rx_has_payload, input ready);
   modport sink (input valid, command, conn_id, now_ms, rx_seq, rx_ack_seq,
                 rx_ack_bits, rx_has_payload, output ready);
endinterface

interface rut_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [2:0]              event_res;
   logic [3:0]              event_conn;
   rut_pkg::seq_type        event_seq;
   rut_pkg::seq_type        tx_ack_seq;
   rut_pkg::window_type     tx_ack_bits;
   logic                    last;
   modport source (output valid, event_res, event_conn, event_seq, tx_ack_seq,
                   tx_ack_bits, last, input ready);
   modport sink (input valid, event_res, event_conn, event_seq, tx_ack_seq,
                 tx_ack_bits, last, output ready);
endinterface

interface rut_csr_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              index;
   logic [31:0]             data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/rut_dp.sv
`default_nettype none
module rut_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rut_pkg::dp_cmd_type    cmd,
   output rut_pkg::dp_status_type status,
   input  rut_pkg::req_item_type  req_item,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [31:0]            csr_data,
   output rut_pkg::rsp_item_type  rsp_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready
);
   localparam int QD = rut_pkg::QUEUE_DEPTH;
   localparam int NS = rut_pkg::SLOTS;
   localparam rut_pkg::seq_type SEQ_HALF = {1'b1, {(rut_pkg::SEQ_BITS-1){1'b0}}};
   localparam rut_pkg::window_type WIN_TOP = {1'b1, {(rut_pkg::ACK_WINDOW-1){1'b0}}};

   function automatic logic seq_after(rut_pkg::seq_type a, rut_pkg::seq_type b);
      rut_pkg::seq_type d;
      d = a - b;
      return (d != '0) && ((d < SEQ_HALF) || ((d == SEQ_HALF) && (a > b)));
   endfunction

   logic                  rcpt_en_ff;
   rut_pkg::time_type     rcpt_to_ff, keep_ff, disc_ff;
   rut_pkg::req_item_type item_ff;

   logic                  active_ff [NS];
   rut_pkg::seq_type      nseq_ff   [NS];
   rut_pkg::seq_type      newest_ff [NS];
   rut_pkg::window_type   win_ff    [NS];
   logic [rut_pkg::READS_W-1:0] reads_ff [NS];
   rut_pkg::time_type     lsend_ff  [NS];
   rut_pkg::time_type     lread_ff  [NS];
   logic [rut_pkg::CNT_W-1:0] pcnt_ff [NS];

   rut_pkg::seq_type      loc_seq_ff [QD];
   rut_pkg::time_type     loc_dl_ff  [QD];
   logic [rut_pkg::CNT_W-1:0] cnt_ff, ld_k_ff, st_k_ff;
   logic                  rdv_ff;
   logic [rut_pkg::QIDX_W-1:0] rdidx_ff;
   logic [rut_pkg::WIDX_W:0]   ack_j_ff;

   rut_pkg::seq_type      mem_seq [NS*QD];
   rut_pkg::time_type     mem_dl  [NS*QD];
   rut_pkg::seq_type      mq_seq_ff;
   rut_pkg::time_type     mq_dl_ff;

   rut_pkg::rsp_item_type hold_ff, out_ff, flush_item;
   logic                  hold_v_ff, out_v_ff;

   logic [rut_pkg::SLOT_W-1:0] c;
   logic                  act, full, send_ok, emit_ok, do_emit, after, found, ack_hit;
   logic [rut_pkg::TIME_W:0] dl_sum, disc_sum;
   rut_pkg::time_type     dl;
   rut_pkg::seq_type      rdiff, ack_q;
   rut_pkg::window_type   shifted;
   logic [rut_pkg::WIDX_W-1:0] ack_idx;
   logic [rut_pkg::QIDX_W-1:0] midx, rm_idx;
   logic                  rm_en;
   logic [rut_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic                  load_go, store_go;
   rut_pkg::rsp_item_type ev;

   assign c        = item_ff.conn_id[rut_pkg::SLOT_W-1:0];
   assign act      = active_ff[c];
   assign full     = rcpt_en_ff && (cnt_ff >= rut_pkg::CNT_W'(QD));
   assign send_ok  = act && !full;
   assign emit_ok  = !hold_v_ff || !out_v_ff || rsp_ready;
   assign dl_sum   = {1'b0, item_ff.now_ms} + {1'b0, rcpt_to_ff};
   assign dl       = dl_sum[rut_pkg::TIME_W] ? '1 : dl_sum[rut_pkg::TIME_W-1:0];
   assign disc_sum = {1'b0, lread_ff[c]} + {1'b0, disc_ff};
   assign rdiff    = item_ff.rx_seq - newest_ff[c];
   assign after    = seq_after(item_ff.rx_seq, newest_ff[c]) || (win_ff[c] == '0);
   assign shifted  = (rdiff >= rut_pkg::seq_type'(rut_pkg::ACK_WINDOW)) ? '0 : (win_ff[c] >> rdiff);
   assign ack_idx  = ack_j_ff[rut_pkg::WIDX_W-1:0];
   assign ack_q    = item_ff.rx_ack_seq - rut_pkg::seq_type'(rut_pkg::ACK_WINDOW - 1)
                     + rut_pkg::seq_type'(ack_idx);
   assign load_go  = (cmd.op == rut_pkg::OP_LOAD) && (ld_k_ff < cnt_ff);
   assign store_go = (cmd.op == rut_pkg::OP_STORE) && (st_k_ff < cnt_ff);
   assign rd_addr  = {c, ld_k_ff[rut_pkg::QIDX_W-1:0]};
   assign wr_addr  = {c, st_k_ff[rut_pkg::QIDX_W-1:0]};

   always_comb begin
      found = 1'b0;
      midx  = '0;
      for (int i = 0; i < QD; i++) begin
         if (!found && (rut_pkg::CNT_W'(i) < cnt_ff) && (loc_seq_ff[i] == ack_q)) begin
            found = 1'b1;
            midx  = rut_pkg::QIDX_W'(i);
         end
      end
   end
   assign ack_hit = item_ff.rx_ack_bits[ack_idx] && found;

   always_comb begin
      ev            = '0;
      ev.event_conn = item_ff.conn_id;
      do_emit       = 1'b0;
      rm_en         = 1'b0;
      rm_idx        = '0;
      case (cmd.op)
         rut_pkg::OP_OPEN: begin
            do_emit      = 1'b1;
            ev.event_res = act ? rut_pkg::EV_REJECT : rut_pkg::EV_OPENED;
         end
         rut_pkg::OP_SEND: begin
            do_emit = 1'b1;
            if (send_ok) begin
               ev.event_res   = rut_pkg::EV_SEND;
               ev.event_seq   = nseq_ff[c];
               ev.tx_ack_seq  = newest_ff[c];
               ev.tx_ack_bits = win_ff[c];
            end else begin
               ev.event_res = rut_pkg::EV_REJECT;
            end
         end
         rut_pkg::OP_ACK: begin
            do_emit      = ack_hit;
            rm_en        = ack_hit;
            rm_idx       = midx;
            ev.event_res = rut_pkg::EV_RCPT_OK;
            ev.event_seq = ack_q;
         end
         rut_pkg::OP_DELIVER: begin
            do_emit      = 1'b1;
            ev.event_res = rut_pkg::EV_DELIVER;
            ev.event_seq = item_ff.rx_seq;
         end
         rut_pkg::OP_FAIL_HEAD: begin
            do_emit      = 1'b1;
            rm_en        = 1'b1;
            ev.event_res = rut_pkg::EV_RCPT_FAIL;
            ev.event_seq = loc_seq_ff[0];
         end
         rut_pkg::OP_DISC: begin
            do_emit      = 1'b1;
            ev.event_res = rut_pkg::EV_DISCONNECT;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rcpt_en_ff <= 1'b1;
         rcpt_to_ff <= 32'd1000;
         keep_ff    <= 32'd500;
         disc_ff    <= 32'd5000;
      end else if (csr_we) begin
         unique case (rut_pkg::csr_index_type'(csr_index))
            rut_pkg::CSR_RCPT_EN:   rcpt_en_ff <= csr_data[0];
            rut_pkg::CSR_RCPT_TO:   rcpt_to_ff <= csr_data;
            rut_pkg::CSR_KEEPALIVE: keep_ff    <= csr_data;
            rut_pkg::CSR_DISC_TO:   disc_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) begin
            active_ff[s] <= 1'b0;
            nseq_ff[s]   <= '0;
            newest_ff[s] <= '0;
            win_ff[s]    <= '0;
            reads_ff[s]  <= '0;
            lsend_ff[s]  <= '0;
            lread_ff[s]  <= '0;
            pcnt_ff[s]   <= '0;
         end
         cnt_ff   <= '0;
         ld_k_ff  <= '0;
         st_k_ff  <= '0;
         ack_j_ff <= '0;
         rdv_ff   <= 1'b0;
         rdidx_ff <= '0;
      end else begin
         rdv_ff <= load_go;
         if (load_go) begin
            rdidx_ff <= ld_k_ff[rut_pkg::QIDX_W-1:0];
            ld_k_ff  <= ld_k_ff + 1'b1;
         end
         if (store_go) begin
            st_k_ff <= st_k_ff + 1'b1;
         end
         if (cmd.latch) begin
            item_ff  <= req_item;
            cnt_ff   <= pcnt_ff[req_item.conn_id[rut_pkg::SLOT_W-1:0]];
            ld_k_ff  <= '0;
            st_k_ff  <= '0;
            ack_j_ff <= '0;
         end
         case (cmd.op)
            rut_pkg::OP_OPEN: begin
               if (!act) begin
                  active_ff[c] <= 1'b1;
                  nseq_ff[c]   <= '0;
                  newest_ff[c] <= '0;
                  win_ff[c]    <= '0;
                  reads_ff[c]  <= '0;
                  lsend_ff[c]  <= '0;
                  lread_ff[c]  <= item_ff.now_ms;
                  pcnt_ff[c]   <= '0;
               end
            end
            rut_pkg::OP_SEND: begin
               if (send_ok) begin
                  nseq_ff[c]  <= nseq_ff[c] + 1'b1;
                  lsend_ff[c] <= item_ff.now_ms;
                  reads_ff[c] <= '0;
                  if (rcpt_en_ff) cnt_ff <= cnt_ff + 1'b1;
               end
            end
            rut_pkg::OP_RXUPD: begin
               lread_ff[c] <= item_ff.now_ms;
               if (reads_ff[c] < rut_pkg::READS_W'(rut_pkg::READ_CAP))
                  reads_ff[c] <= reads_ff[c] + 1'b1;
               if (after) begin
                  win_ff[c]    <= shifted | WIN_TOP;
                  newest_ff[c] <= item_ff.rx_seq;
               end
            end
            rut_pkg::OP_ACK: begin
               ack_j_ff <= ack_j_ff + 1'b1;
               if (ack_hit) cnt_ff <= cnt_ff - 1'b1;
            end
            rut_pkg::OP_FAIL_HEAD: cnt_ff <= cnt_ff - 1'b1;
            rut_pkg::OP_DISC: begin
               active_ff[c] <= 1'b0;
               cnt_ff       <= '0;
            end
            rut_pkg::OP_STORE: pcnt_ff[c] <= cnt_ff;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rdv_ff) begin
         loc_seq_ff[rdidx_ff] <= mq_seq_ff;
         loc_dl_ff[rdidx_ff]  <= mq_dl_ff;
      end
      if (rm_en) begin
         for (int k = 0; k < QD - 1; k++) begin
            if (rut_pkg::QIDX_W'(k) >= rm_idx) begin
               loc_seq_ff[k] <= loc_seq_ff[k+1];
               loc_dl_ff[k]  <= loc_dl_ff[k+1];
            end
         end
      end
      if ((cmd.op == rut_pkg::OP_SEND) && send_ok && rcpt_en_ff) begin
         loc_seq_ff[cnt_ff[rut_pkg::QIDX_W-1:0]] <= nseq_ff[c];
         loc_dl_ff[cnt_ff[rut_pkg::QIDX_W-1:0]]  <= dl;
      end
   end

   always_ff @(posedge clock) begin
      mq_seq_ff <= mem_seq[rd_addr];
      mq_dl_ff  <= mem_dl[rd_addr];
      if (store_go) begin
         mem_seq[wr_addr] <= loc_seq_ff[st_k_ff[rut_pkg::QIDX_W-1:0]];
         mem_dl[wr_addr]  <= loc_dl_ff[st_k_ff[rut_pkg::QIDX_W-1:0]];
      end
   end

   always_comb begin
      flush_item      = hold_ff;
      flush_item.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (do_emit) begin
            if (hold_v_ff) begin
               out_ff   <= hold_ff;
               out_v_ff <= 1'b1;
            end else if (out_v_ff && rsp_ready) begin
               out_v_ff <= 1'b0;
            end
            hold_ff   <= ev;
            hold_v_ff <= 1'b1;
         end else if ((cmd.op == rut_pkg::OP_FLUSH) && hold_v_ff &&
                      (!out_v_ff || rsp_ready)) begin
            out_ff    <= flush_item;
            out_v_ff  <= 1'b1;
            hold_v_ff <= 1'b0;
         end else if (out_v_ff && rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_item  = out_ff;
   assign rsp_valid = out_v_ff;

   always_comb begin
      status            = '0;
      status.cmd        = rut_pkg::cmd_type'(item_ff.command);
      status.active     = act;
      status.rcpt       = rcpt_en_ff;
      status.pay        = item_ff.rx_has_payload;
      status.emit_ok    = emit_ok;
      status.load_done  = (ld_k_ff == cnt_ff) && !rdv_ff;
      status.store_done = (st_k_ff == cnt_ff);
      status.hold_v     = hold_v_ff;
      status.force_ack  = reads_ff[c] > rut_pkg::READS_W'(rut_pkg::ACK_WINDOW / 4);
      status.keep_due   = (item_ff.now_ms - lsend_ff[c]) > keep_ff;
      status.expire_due = (cnt_ff != '0) && (loc_dl_ff[0] <= item_ff.now_ms);
      status.disc_due   = disc_sum < {1'b0, item_ff.now_ms};
      status.ack_done   = ack_j_ff[rut_pkg::WIDX_W];
      status.cnt_zero   = (cnt_ff == '0);
      status.cnt        = cnt_ff;
   end
endmodule
`default_nettype wire

>>> hdl/rut_ctrl.sv
`default_nettype none
module rut_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output rut_pkg::dp_cmd_type    cmd,
   input  rut_pkg::dp_status_type status
);
   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_OPEN, S_LOAD, S_SEND, S_RXUPD, S_RXFORCE, S_ACK,
      S_DELIV, S_KEEP, S_EXPIRE, S_DISC, S_DRAIN, S_STORE, S_FLUSH
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_ready = ready_ff;

   always_comb begin
      cmd.latch = req_valid && ready_ff;
      cmd.op    = rut_pkg::OP_NONE;
      unique case (state_ff)
         S_OPEN:    if (status.emit_ok) cmd.op = rut_pkg::OP_OPEN;
         S_LOAD:    cmd.op = rut_pkg::OP_LOAD;
         S_SEND:    if (status.emit_ok) cmd.op = rut_pkg::OP_SEND;
         S_RXUPD:   cmd.op = rut_pkg::OP_RXUPD;
         S_RXFORCE: if (status.force_ack && status.emit_ok) cmd.op = rut_pkg::OP_SEND;
         S_ACK:     if (status.rcpt && !status.ack_done && status.emit_ok)
                       cmd.op = rut_pkg::OP_ACK;
         S_DELIV:   if (status.pay && status.emit_ok) cmd.op = rut_pkg::OP_DELIVER;
         S_KEEP:    if (status.keep_due && status.emit_ok) cmd.op = rut_pkg::OP_SEND;
         S_EXPIRE:  if (status.expire_due && status.emit_ok) cmd.op = rut_pkg::OP_FAIL_HEAD;
         S_DRAIN:   if (status.emit_ok)
                       cmd.op = status.cnt_zero ? rut_pkg::OP_DISC : rut_pkg::OP_FAIL_HEAD;
         S_STORE:   cmd.op = rut_pkg::OP_STORE;
         S_FLUSH:   cmd.op = rut_pkg::OP_FLUSH;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ready_ff <= 1'b1;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid && ready_ff) begin
               ready_ff <= 1'b0;
               state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               unique case (status.cmd)
                  rut_pkg::CMD_OPEN: state_ff <= S_OPEN;
                  rut_pkg::CMD_SEND: state_ff <= status.active ? S_LOAD : S_SEND;
                  default:           state_ff <= status.active ? S_LOAD : S_FLUSH;
               endcase
            end
            S_OPEN: if (status.emit_ok) state_ff <= S_FLUSH;
            S_LOAD: if (status.load_done) begin
               unique case (status.cmd)
                  rut_pkg::CMD_SEND: state_ff <= S_SEND;
                  rut_pkg::CMD_RECV: state_ff <= S_RXUPD;
                  default:           state_ff <= S_KEEP;
               endcase
            end
            S_SEND: if (status.emit_ok) state_ff <= status.active ? S_STORE : S_FLUSH;
            S_RXUPD: state_ff <= S_RXFORCE;
            S_RXFORCE: if (!status.force_ack || status.emit_ok) state_ff <= S_ACK;
            S_ACK: if (!status.rcpt || status.ack_done) state_ff <= S_DELIV;
            S_DELIV: if (!status.pay || status.emit_ok) state_ff <= S_STORE;
            S_KEEP: if (!status.keep_due || status.emit_ok) state_ff <= S_EXPIRE;
            S_EXPIRE: if (!status.expire_due) state_ff <= S_DISC;
            S_DISC: state_ff <= status.disc_due ? S_DRAIN : S_STORE;
            S_DRAIN: if (status.emit_ok && status.cnt_zero) state_ff <= S_STORE;
            S_STORE: if (status.store_done) state_ff <= S_FLUSH;
            S_FLUSH: if (!status.hold_v) begin
               state_ff <= S_IDLE;
               ready_ff <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> hdl/reliable_udp_ack_tracker_top.sv
// Channel  Dir  Handshake      Carries
// req_ch   in   valid/ready    command, slot, time, received header fields
// rsp_ch   out  valid/ready    the events of a transaction, last marks its final event
// csr_ch   in   valid/ready    register index and write data, always ready
// While an item is handled, from accept to ready, the slot's queue is copied in
// from the queue memory one entry a cycle, ack matching walks the 32 window bits
// one a cycle while rsp_ch does not stall, and the queue is written back one entry a cycle.
// Reset is synchronous; all slots come up closed, no clearing pass.
// A stalled rsp_ch holds the sequencer at its next event.
`default_nettype none
`include "assert_macros.svh"
module reliable_udp_ack_tracker_top (
   input  logic      clock,
   input  logic      reset,
   rut_req_if.sink   req_ch,
   rut_rsp_if.source rsp_ch,
   rut_csr_if.sink   csr_ch
);
   rut_pkg::dp_cmd_type    dp_cmd;
   rut_pkg::dp_status_type dp_status;
   rut_pkg::req_item_type  req_item;
   rut_pkg::rsp_item_type  rsp_item;
   logic                   req_ready;
   logic                   rsp_valid;

   assign req_item.command        = req_ch.command;
   assign req_item.conn_id        = req_ch.conn_id;
   assign req_item.now_ms         = req_ch.now_ms;
   assign req_item.rx_seq         = req_ch.rx_seq;
   assign req_item.rx_ack_seq     = req_ch.rx_ack_seq;
   assign req_item.rx_ack_bits    = req_ch.rx_ack_bits;
   assign req_item.rx_has_payload = req_ch.rx_has_payload;
   assign req_ch.ready            = req_ready;
   assign csr_ch.ready            = 1'b1;

   rut_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   rut_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .req_item  (req_item),
      .csr_we    (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .rsp_item  (rsp_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready)
   );

   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.event_res   = rsp_item.event_res;
   assign rsp_ch.event_conn  = rsp_item.event_conn;
   assign rsp_ch.event_seq   = rsp_item.event_seq;
   assign rsp_ch.tx_ack_seq  = rsp_item.tx_ack_seq;
   assign rsp_ch.tx_ack_bits = rsp_item.tx_ack_bits;
   assign rsp_ch.last        = rsp_item.last;

   `ASSERT_IMPLIES(a_accept_no_held_event, clock, reset, req_ch.valid && req_ch.ready, !dp_status.hold_v, "transaction accepted with an event still held")
   `ASSERT_IMPLIES(a_idle_no_op, clock, reset, req_ch.ready, dp_cmd.op == rut_pkg::OP_NONE, "datapath operation while idle")
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, dp_status.cnt <= rut_pkg::CNT_W'(rut_pkg::QUEUE_DEPTH), "sent queue overflow")
endmodule
`default_nettype wire
